// ----- hdl/srp_pkg.sv -----
// Types, constants and helpers shared by the symbol width repacker.
// No dependencies; compile first.
`default_nettype none

package srp_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int WIDTH_W     = 4;
  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [SYMBOL_BITS-1:0] sym_t;
  typedef logic [WIDTH_W-1:0]     width_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam width_t   SYM_BITS_W   = width_t'(SYMBOL_BITS);
  localparam cfg_idx_t CFG_IN_BITS  = 1'b0;
  localparam cfg_idx_t CFG_OUT_BITS = 1'b1;

  typedef struct packed {
    logic   pass;
    logic   last;
    sym_t   data;
    width_t rem;
  } srp_entry_t;

  function automatic width_t eff_width(width_t w);
    width_t r;
    if (w == '0) begin
      r = width_t'(1);
    end else if (w > SYM_BITS_W) begin
      r = SYM_BITS_W;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/srp_stream_if.sv -----
// Valid/ready stream channel carrying one symbol and a last flag.
// Depends on srp_pkg.
`default_nettype none

interface srp_stream_if;
  import srp_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol;
  logic last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
  modport mon    (input valid, input symbol, input last, input ready);
endinterface

`default_nettype wire

// ----- hdl/srp_front.sv -----
// Front end: accepts input items and classifies them into queue entries.
// Depends on srp_pkg and srp_stream_if.
`default_nettype none

module srp_front import srp_pkg::*; (
  srp_stream_if.sink  in_ch,
  input  width_t      ib,
  input  width_t      ob,
  input  logic        q_full,
  output logic        push,
  output srp_entry_t  entry
);

  width_t align_shift;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign align_shift = SYM_BITS_W - ib;

  always_comb begin
    entry.pass = (ib == ob);
    entry.last = in_ch.last;
    entry.rem  = ib;
    if (ib == ob) begin
      entry.data = in_ch.symbol;
    end else begin
      entry.data = sym_t'(in_ch.symbol << align_shift);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/srp_queue.sv -----
// Two-entry queue between the front and back ends.
// Depends on srp_pkg.
`default_nettype none

module srp_queue import srp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  srp_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output srp_entry_t head
);

  srp_entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QCNT_W-1:0]       count_r;
  logic [QCNT_W-1:0]       count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/srp_back.sv -----
// Back end: bit accumulator that packs entries into output symbols.
// Depends on srp_pkg and srp_stream_if.
`default_nettype none

module srp_back import srp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  srp_entry_t  head,
  output logic        pop,
  input  width_t      ob,
  input  logic        cfg_clear,
  srp_stream_if.source out_ch
);

  logic   started_r;
  sym_t   bits_r;
  width_t rem_r;
  sym_t   acc_r;
  sym_t   acc_nxt;
  cnt_t   cnt_r;
  cnt_t   cnt_nxt;
  logic   out_valid_r;
  sym_t   out_symbol_r;
  logic   out_last_r;

  sym_t        cur_bits;
  width_t      cur_rem;
  width_t      need;
  width_t      take;
  width_t      rem_after;
  width_t      cnt_sum;
  width_t      pad_shift;
  sym_t        top_bits;
  sym_t        bits_after;
  logic [15:0] acc_wide;
  sym_t        new_acc;
  sym_t        padded;
  logic        step;
  logic        emit;
  logic        done;
  sym_t        emit_sym;
  logic        emit_last;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_symbol_r;
  assign out_ch.last   = out_last_r;

  assign cur_bits   = started_r ? bits_r : head.data;
  assign cur_rem    = started_r ? rem_r : head.rem;
  assign need       = ob - width_t'(cnt_r);
  assign take       = (cur_rem < need) ? cur_rem : need;
  assign top_bits   = cur_bits >> (SYM_BITS_W - take);
  assign acc_wide   = {8'h00, acc_r} << take;
  assign new_acc    = acc_wide[7:0] | top_bits;
  assign rem_after  = cur_rem - take;
  assign bits_after = cur_bits << take;
  assign cnt_sum    = width_t'(cnt_r) + cur_rem;
  assign pad_shift  = ob - cnt_sum;
  assign padded     = new_acc << pad_shift;
  assign step       = head_valid && (!out_valid_r || out_ch.ready);
  assign pop        = step && done;

  always_comb begin
    emit      = 1'b0;
    emit_sym  = '0;
    emit_last = 1'b0;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    if (head.pass) begin
      emit      = 1'b1;
      emit_sym  = head.data;
      emit_last = head.last;
      done      = 1'b1;
      if (head.last) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end
    end else if (take == need) begin
      emit      = 1'b1;
      emit_sym  = new_acc;
      emit_last = head.last && (rem_after == '0);
      acc_nxt   = '0;
      cnt_nxt   = '0;
      done      = (rem_after == '0);
    end else begin
      done = 1'b1;
      if (head.last) begin
        emit      = 1'b1;
        emit_sym  = padded;
        emit_last = 1'b1;
        acc_nxt   = '0;
        cnt_nxt   = '0;
      end else begin
        acc_nxt = new_acc;
        cnt_nxt = cnt_t'(cnt_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_clear) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else if (step) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
      if (step) begin
        started_r <= !done;
      end
      if (step && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      bits_r <= bits_after;
      rem_r  <= rem_after;
    end
    if (step && emit) begin
      out_symbol_r <= emit_sym;
      out_last_r   <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/symbol_width_repacker.sv -----
// Top level of the symbol width repacker: width registers, front, queue, back.
// Depends on srp_pkg, srp_stream_if, srp_front, srp_queue and srp_back.
//
// Repacks in_bits-bit symbols into out_bits-bit symbols, MSB first, zero
// padding the final partial symbol of a packet. The back end emits at most
// one output symbol per cycle from a single output register. It works on an
// item in steps, each emitting at most one output symbol; a non-last item
// whose final bits only enter the accumulator needs a step that emits
// nothing. Items of equal widths pass straight through, and 8-bit in to 1-bit
// out gives the most output symbols per item. The back end holds while the
// output register waits on out_ch.ready. The first result of an item passes
// through the queue and then the output register. A two-entry queue lets new
// items enter while the back end is still busy or stalled. Width writes clear
// the accumulator; write them only while idle.
`default_nettype none

module symbol_width_repacker import srp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  srp_stream_if.sink    in_ch,
  srp_stream_if.source  out_ch,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  cfg_data_t     cfg_data
);

  width_t     in_bits_r;
  width_t     out_bits_r;
  width_t     ib;
  width_t     ob;
  logic       cfg_clear;
  logic       q_full;
  logic       push;
  srp_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  srp_entry_t head;

  assign ib        = eff_width(in_bits_r);
  assign ob        = eff_width(out_bits_r);
  assign cfg_clear = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r  <= SYM_BITS_W;
      out_bits_r <= SYM_BITS_W;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_BITS:  in_bits_r  <= width_t'(cfg_data);
        CFG_OUT_BITS: out_bits_r <= width_t'(cfg_data);
        default: ;
      endcase
    end
  end

  srp_front u_front (
    .in_ch  (in_ch),
    .ib     (ib),
    .ob     (ob),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  srp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  srp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ob         (ob),
    .cfg_clear  (cfg_clear),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- hdl/srp_checker.sv -----
// Port-level checks for the symbol width repacker, bound to the top level.
// Depends on srp_pkg and symbol_width_repacker.
`default_nettype none

module srp_checker import srp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sym_t out_symbol,
  input logic out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
    else $error("output item changed while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind symbol_width_repacker srp_checker u_srp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_last   (out_ch.last)
);

`default_nettype wire
